>>> sv/bdd_pkg.sv
// Shared types, constants and helper functions for the bicycle dynamics
// derivative core. No dependencies.
package bdd_pkg;

    localparam int WORD_W        = 48;
    localparam int REG_W         = 47;
    localparam int CFG_IDX_W     = 3;
    localparam int CORDIC_ITERS  = 30;
    localparam int MUL_LAT       = 4;
    localparam int FRAC_BITS_DEF = 24;
    localparam int ANG_W         = 35;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRONT_AXLE  = 3'd0,
        CFG_REAR_AXLE   = 3'd1,
        CFG_FRONT_STIFF = 3'd2,
        CFG_REAR_STIFF  = 3'd3,
        CFG_INV_MASS    = 3'd4,
        CFG_INV_YAW     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] heading;
        logic signed [WORD_W-1:0] long_vel;
        logic signed [WORD_W-1:0] lat_vel;
        logic signed [WORD_W-1:0] turn_rate;
        logic signed [WORD_W-1:0] wheel_angle;
        logic signed [WORD_W-1:0] accel_cmd;
        logic signed [WORD_W-1:0] steer_rate_cmd;
    } state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] d_pos_x;
        logic signed [WORD_W-1:0] d_pos_y;
        logic signed [WORD_W-1:0] d_heading;
        logic signed [WORD_W-1:0] d_long_vel;
        logic signed [WORD_W-1:0] d_lat_vel;
        logic signed [WORD_W-1:0] d_turn_rate;
        logic signed [WORD_W-1:0] d_wheel_angle;
    } deriv_t;

    // Angles in Q2.30
    localparam logic signed [ANG_W-1:0] PI30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI30  = 35'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI30 = 35'sd1686629713;
    localparam logic [63:0]             TWO_PI61  = 64'h6487ED5110B4611A;
    localparam logic [31:0]             KINV30    = 32'd652032874;

    localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535,
        32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
        32'd1023, 32'd511, 32'd255, 32'd127, 32'd63,
        32'd31, 32'd15, 32'd7, 32'd3, 32'd1
    };

    function automatic logic signed [WORD_W+1:0] sx50(input logic signed [WORD_W-1:0] v);
        return {{2{v[WORD_W-1]}}, v};
    endfunction

    function automatic logic signed [WORD_W-1:0] sat48(input logic signed [WORD_W+1:0] v);
        logic signed [WORD_W+1:0] hi;
        logic signed [WORD_W+1:0] lo;
        hi = {3'b000, {(WORD_W-1){1'b1}}};
        lo = {3'b111, {(WORD_W-1){1'b0}}};
        if (v > hi)
            return WORD_W'(hi);
        else if (v < lo)
            return WORD_W'(lo);
        else
            return WORD_W'(v);
    endfunction

    // One doubling step of the residue modulo 2*pi at scale 2^60
    function automatic logic [63:0] red_step(input logic [63:0] r);
        logic [63:0] r2;
        r2 = {r[62:0], 1'b0};
        return (r2 >= TWO_PI61) ? r2 - TWO_PI61 : r2;
    endfunction

endpackage

>>> sv/bdd_mul.sv
// Pipelined signed 48x48 multiply, rounded shift and saturation to 48 bits.
// Built from four 24x24 partial products. Depends on bdd_pkg.
module bdd_mul
    import bdd_pkg::*;
#(
    parameter int SHIFT = FRAC_BITS_DEF
)(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [WORD_W-1:0] a,
    input  logic signed [WORD_W-1:0] b,
    output logic signed [WORD_W-1:0] p
);

    localparam int HW = WORD_W / 2;
    localparam int PW = 2 * WORD_W;

    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [WORD_W-1:0] ma_reg, mb_reg, ma_next, mb_next;
    logic [2*HW-1:0]   pll_reg, plh_reg, phl_reg, phh_reg;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [PW:0]       rnd, q, lim, qs;
    logic signed [WORD_W-1:0] p_reg, p_next;

    assign ma_next = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
    assign mb_next = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);

    assign prod_next = PW'(pll_reg) + (PW'(plh_reg) << HW) + (PW'(phl_reg) << HW)
                     + (PW'(phh_reg) << (2 * HW));

    always_comb
    begin
        rnd = {1'b0, prod_reg} + ((PW+1)'(1) << (SHIFT - 1));
        q   = rnd >> SHIFT;
        lim = ((PW+1)'(1) << (WORD_W - 1)) - (PW+1)'(!neg3_reg);
        qs  = (q > lim) ? lim : q;
        p_next = neg3_reg ? -$signed(qs[WORD_W-1:0]) : $signed(qs[WORD_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a[WORD_W-1] ^ b[WORD_W-1];
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            neg2_reg <= neg1_reg;
            pll_reg  <= ma_reg[HW-1:0] * mb_reg[HW-1:0];
            plh_reg  <= ma_reg[HW-1:0] * mb_reg[WORD_W-1:HW];
            phl_reg  <= ma_reg[WORD_W-1:HW] * mb_reg[HW-1:0];
            phh_reg  <= ma_reg[WORD_W-1:HW] * mb_reg[WORD_W-1:HW];
            neg3_reg <= neg2_reg;
            prod_reg <= prod_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> sv/bdd_cordic.sv
// Fully pipelined CORDIC, one iteration per stage, rotation or vectoring mode.
// Carries a one-bit tag alongside. Depends on bdd_pkg.
module bdd_cordic
    import bdd_pkg::*;
#(
    parameter int XW     = 36,
    parameter int ZW     = ANG_W,
    parameter bit VECTOR = 1'b0
)(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    input  logic                 tag_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [ZW-1:0] z_out,
    output logic                 tag_out
);

    logic signed [XW-1:0] x_reg [CORDIC_ITERS];
    logic signed [XW-1:0] y_reg [CORDIC_ITERS];
    logic signed [ZW-1:0] z_reg [CORDIC_ITERS];
    logic                 tag_reg [CORDIC_ITERS];

    for (genvar k = 0; k < CORDIC_ITERS; k++)
    begin : g_it
        logic signed [XW-1:0] xp, yp, dx, dy;
        logic signed [ZW-1:0] zp, at;
        logic                 tp, up;

        if (k == 0)
        begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign zp = z_in;
            assign tp = tag_in;
        end
        else
        begin : g_next
            assign xp = x_reg[k-1];
            assign yp = y_reg[k-1];
            assign zp = z_reg[k-1];
            assign tp = tag_reg[k-1];
        end

        assign dx = yp >>> k;
        assign dy = xp >>> k;
        assign at = ZW'(ATAN_TAB[k]);
        // rotation drives z to zero, vectoring drives y to zero
        assign up = VECTOR ? !yp[XW-1] : zp[ZW-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]   <= up ? xp + dx : xp - dx;
                y_reg[k]   <= up ? yp - dy : yp + dy;
                z_reg[k]   <= up ? zp + at : zp - at;
                tag_reg[k] <= tp;
            end
        end
    end

    assign x_out   = x_reg[CORDIC_ITERS-1];
    assign y_out   = y_reg[CORDIC_ITERS-1];
    assign z_out   = z_reg[CORDIC_ITERS-1];
    assign tag_out = tag_reg[CORDIC_ITERS-1];

endmodule

>>> sv/bicycle_dynamics_derivative_core.sv
// Top level of the bicycle dynamics derivative core: config registers,
// pipeline control and datapath. Depends on bdd_pkg, bdd_mul, bdd_cordic.
//
//  channel  | signals                                | word
//  ---------+----------------------------------------+------------------
//  item     | item_valid, item_ready, item           | state_t, in
//  deriv    | deriv_valid, deriv_ready, deriv        | deriv_t, out
//  cfg      | cfg_we, cfg_index, cfg_data            | 47-bit register
//
// One word per cycle enters and leaves while the output is not stalled. The
// pipeline depth is set by the modulo-2*pi reduction of the angles
// (61 - FRAC_BITS steps) and the 30-stage CORDIC, then three chained
// multiplies and the registers between them.
// All stages advance together; a stalled output freezes the whole pipe.
// Reset clears the valid bits and loads the register defaults.
module bicycle_dynamics_derivative_core
    import bdd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  state_t               item,
    output logic                 deriv_valid,
    input  logic                 deriv_ready,
    output deriv_t               deriv,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    localparam int LM    = MUL_LAT;
    localparam int RS    = 61 - FRAC_BITS;
    localparam int SC_IN = RS + 3;
    localparam int B     = SC_IN + CORDIC_ITERS + 1;
    localparam int D     = B - 2 * LM - CORDIC_ITERS - 3;
    localparam int P     = B + 3 * LM + 1;
    localparam int SC_XW = 36;
    localparam int AT_XW = 52;

    localparam int S30    = 30 - FRAC_BITS;
    localparam int RND_SH = (S30 > 0) ? S30 - 1 : 0;
    localparam int DN_SH  = (S30 > 0) ? S30 : 0;
    localparam int UP_SH  = (S30 < 0) ? -S30 : 0;
    localparam logic [WORD_W+1:0] RND_ADD = (S30 > 0) ? (WORD_W+2)'(1) << RND_SH : '0;

    localparam logic signed [WORD_W-1:0] VX_MIN =
        WORD_W'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);
    localparam logic [REG_W-1:0] ONE_Q = REG_W'(64'd1 << FRAC_BITS);

    // Q2.30 angle to the field format, ties away from zero
    function automatic logic signed [WORD_W+1:0] from30(input logic signed [ANG_W-1:0] v);
        logic [WORD_W+1:0] m;
        m = v[ANG_W-1] ? (WORD_W+2)'(-v) : (WORD_W+2)'(v);
        m = ((m + RND_ADD) >> DN_SH) << UP_SH;
        return v[ANG_W-1] ? -$signed(m) : $signed(m);
    endfunction

    // ---------------- configuration ----------------
    logic [REG_W-1:0] front_axle_dist_reg, rear_axle_dist_reg;
    logic [REG_W-1:0] front_cornering_stiff_reg, rear_cornering_stiff_reg;
    logic [REG_W-1:0] inv_mass_reg, inv_yaw_inertia_reg;
    logic signed [WORD_W-1:0] lf, lr, cf, cr, im, iy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_axle_dist_reg       <= ONE_Q;
            rear_axle_dist_reg        <= ONE_Q;
            front_cornering_stiff_reg <= '0;
            rear_cornering_stiff_reg  <= '0;
            inv_mass_reg              <= '0;
            inv_yaw_inertia_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRONT_AXLE:  front_axle_dist_reg       <= cfg_data;
                CFG_REAR_AXLE:   rear_axle_dist_reg        <= cfg_data;
                CFG_FRONT_STIFF: front_cornering_stiff_reg <= cfg_data;
                CFG_REAR_STIFF:  rear_cornering_stiff_reg  <= cfg_data;
                CFG_INV_MASS:    inv_mass_reg              <= cfg_data;
                CFG_INV_YAW:     inv_yaw_inertia_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    assign lf = $signed({1'b0, front_axle_dist_reg});
    assign lr = $signed({1'b0, rear_axle_dist_reg});
    assign cf = $signed({1'b0, front_cornering_stiff_reg});
    assign cr = $signed({1'b0, rear_cornering_stiff_reg});
    assign im = $signed({1'b0, inv_mass_reg});
    assign iy = $signed({1'b0, inv_yaw_inertia_reg});

    // ---------------- pipeline control ----------------
    logic       en;
    logic [P:0] vld_reg;
    state_t     item_reg [P+1];

    assign en          = !vld_reg[P] || deriv_ready;
    assign item_ready  = en;
    assign deriv_valid = vld_reg[P];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[P-1:0], item_valid};
    end

    // carry the input word down the whole pipe; stages tap it where needed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= item;
            for (int i = 1; i <= P; i++)
                item_reg[i] <= item_reg[i-1];
        end
    end

    // ---------------- sin/cos of heading and wheel angle ----------------
    logic signed [ANG_W-1:0]  sc_z_reg [2];
    logic                     sc_flip_reg [2];
    logic signed [WORD_W-1:0] cos_reg [2];
    logic signed [WORD_W-1:0] sin_h_reg;

    for (genvar g = 0; g < 2; g++)
    begin : g_sc
        logic signed [WORD_W-1:0] ang;
        logic [WORD_W-1:0]        mag;
        logic [63:0]              red_reg [RS+1];
        logic                     neg_reg [RS+1];
        logic [63:0]              r_fin, rnd;
        logic signed [ANG_W-1:0]  a_reg, w, z_next;
        logic                     flip_next;
        logic signed [SC_XW-1:0]  xo, yo;
        logic                     flip_o;

        assign ang = (g == 0) ? item_reg[0].heading : item_reg[0].wheel_angle;
        assign mag = ang[WORD_W-1] ? WORD_W'(-ang) : WORD_W'(ang);

        assign r_fin = (neg_reg[RS] && red_reg[RS] != '0) ? TWO_PI61 - red_reg[RS]
                                                          : red_reg[RS];
        assign rnd   = r_fin + (64'd1 << 30);

        always_comb
        begin
            w         = (a_reg > PI30) ? a_reg - TWO_PI30 : a_reg;
            z_next    = w;
            flip_next = 1'b0;
            // fold into the right half plane
            if (w > HALF_PI30)
            begin
                z_next    = w - PI30;
                flip_next = 1'b1;
            end
            else if (w < -HALF_PI30)
            begin
                z_next    = w + PI30;
                flip_next = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                red_reg[0] <= 64'(mag);
                neg_reg[0] <= ang[WORD_W-1];
                for (int j = 1; j <= RS; j++)
                begin
                    red_reg[j] <= red_step(red_reg[j-1]);
                    neg_reg[j] <= neg_reg[j-1];
                end
                a_reg          <= ANG_W'(rnd[63:31]);
                sc_z_reg[g]    <= z_next;
                sc_flip_reg[g] <= flip_next;
                cos_reg[g]     <= flip_o ? -WORD_W'(xo) : WORD_W'(xo);
            end
        end

        bdd_cordic #(
            .XW     (SC_XW),
            .ZW     (ANG_W),
            .VECTOR (1'b0)
        ) u_cordic (
            .clk     (clk),
            .en      (en),
            .x_in    (SC_XW'(KINV30)),
            .y_in    ('0),
            .z_in    (sc_z_reg[g]),
            .tag_in  (sc_flip_reg[g]),
            .x_out   (xo),
            .y_out   (yo),
            .z_out   (),
            .tag_out (flip_o)
        );

        if (g == 0)
        begin : g_sin
            always_ff @(posedge clk)
            begin
                if (en)
                    sin_h_reg <= flip_o ? -WORD_W'(yo) : WORD_W'(yo);
            end
        end
    end

    // ---------------- slip angles and tire forces ----------------
    logic signed [WORD_W-1:0] p_lfr, p_lrr;
    logic signed [WORD_W-1:0] ya_reg, yb_reg, vxs_reg, vx4, vy4;
    logic signed [AT_XW-1:0]  at_x_reg, at_ya_reg, at_yb_reg;
    logic signed [ANG_W-1:0]  at_za_reg, at_zb_reg, za, zb;
    logic signed [WORD_W-1:0] af_reg, ar_reg, fyf, fyr;

    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_lfr (
        .clk(clk), .en(en), .a(lf), .b(item_reg[D].turn_rate), .p(p_lfr));
    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_lrr (
        .clk(clk), .en(en), .a(lr), .b(item_reg[D].turn_rate), .p(p_lrr));

    assign vx4 = item_reg[D+LM].long_vel;
    assign vy4 = item_reg[D+LM].lat_vel;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ya_reg <= sat48(sx50(vy4) + sx50(p_lfr));
            yb_reg <= sat48(sx50(vy4) - sx50(p_lrr));
            // hold speed away from zero, zero counts as forward
            if (vx4 < VX_MIN && vx4 > -VX_MIN)
                vxs_reg <= vx4[WORD_W-1] ? -VX_MIN : VX_MIN;
            else
                vxs_reg <= vx4;
            // move the vector into the right half plane
            if (vxs_reg[WORD_W-1])
            begin
                at_x_reg  <= -AT_XW'(vxs_reg);
                at_ya_reg <= -AT_XW'(ya_reg);
                at_yb_reg <= -AT_XW'(yb_reg);
                at_za_reg <= ya_reg[WORD_W-1] ? -PI30 : PI30;
                at_zb_reg <= yb_reg[WORD_W-1] ? -PI30 : PI30;
            end
            else
            begin
                at_x_reg  <= AT_XW'(vxs_reg);
                at_ya_reg <= AT_XW'(ya_reg);
                at_yb_reg <= AT_XW'(yb_reg);
                at_za_reg <= '0;
                at_zb_reg <= '0;
            end
            af_reg <= sat48(sx50(item_reg[D+6+CORDIC_ITERS].wheel_angle) - from30(za));
            ar_reg <= WORD_W'(-from30(zb));
        end
    end

    bdd_cordic #(.XW(AT_XW), .ZW(ANG_W), .VECTOR(1'b1)) u_atan_f (
        .clk(clk), .en(en), .x_in(at_x_reg), .y_in(at_ya_reg), .z_in(at_za_reg),
        .tag_in(1'b0), .x_out(), .y_out(), .z_out(za), .tag_out());
    bdd_cordic #(.XW(AT_XW), .ZW(ANG_W), .VECTOR(1'b1)) u_atan_r (
        .clk(clk), .en(en), .x_in(at_x_reg), .y_in(at_yb_reg), .z_in(at_zb_reg),
        .tag_in(1'b0), .x_out(), .y_out(), .z_out(zb), .tag_out());

    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_ff (
        .clk(clk), .en(en), .a(cf), .b(af_reg), .p(fyf));
    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_fr (
        .clk(clk), .en(en), .a(cr), .b(ar_reg), .p(fyr));

    // ---------------- derivative assembly ----------------
    logic signed [WORD_W-1:0] fyfc, xc, ys, xs, yc, vyr, vxr, lff, lrf, massm, d5;
    logic signed [WORD_W-1:0] sumf_reg, diff_reg;
    logic signed [WORD_W-1:0] fyr_dl_reg [LM];
    logic signed [WORD_W-1:0] vxr_dl_reg [LM+1];
    logic signed [WORD_W-1:0] d0_dl_reg [2*LM+1];
    logic signed [WORD_W-1:0] d1_dl_reg [2*LM+1];
    logic signed [WORD_W-1:0] d3_dl_reg [2*LM+1];
    logic signed [WORD_W-1:0] d4_dl_reg [LM];

    bdd_mul #(.SHIFT(30)) u_mul_fc (
        .clk(clk), .en(en), .a(fyf), .b(cos_reg[1]), .p(fyfc));
    bdd_mul #(.SHIFT(30)) u_mul_xc (
        .clk(clk), .en(en), .a(item_reg[B].long_vel), .b(cos_reg[0]), .p(xc));
    bdd_mul #(.SHIFT(30)) u_mul_ys (
        .clk(clk), .en(en), .a(item_reg[B].lat_vel), .b(sin_h_reg), .p(ys));
    bdd_mul #(.SHIFT(30)) u_mul_xs (
        .clk(clk), .en(en), .a(item_reg[B].long_vel), .b(sin_h_reg), .p(xs));
    bdd_mul #(.SHIFT(30)) u_mul_yc (
        .clk(clk), .en(en), .a(item_reg[B].lat_vel), .b(cos_reg[0]), .p(yc));
    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_vyr (
        .clk(clk), .en(en), .a(item_reg[B].lat_vel), .b(item_reg[B].turn_rate), .p(vyr));
    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_vxr (
        .clk(clk), .en(en), .a(item_reg[B].long_vel), .b(item_reg[B].turn_rate), .p(vxr));

    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_lff (
        .clk(clk), .en(en), .a(lf), .b(fyfc), .p(lff));
    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_lrf (
        .clk(clk), .en(en), .a(lr), .b(fyr_dl_reg[LM-1]), .p(lrf));
    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_mass (
        .clk(clk), .en(en), .a(sumf_reg), .b(im), .p(massm));
    bdd_mul #(.SHIFT(FRAC_BITS)) u_mul_yaw (
        .clk(clk), .en(en), .a(diff_reg), .b(iy), .p(d5));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fyr_dl_reg[0] <= fyr;
            for (int i = 1; i < LM; i++)
                fyr_dl_reg[i] <= fyr_dl_reg[i-1];

            vxr_dl_reg[0] <= vxr;
            for (int i = 1; i <= LM; i++)
                vxr_dl_reg[i] <= vxr_dl_reg[i-1];

            sumf_reg     <= sat48(sx50(fyfc) + sx50(fyr_dl_reg[LM-1]));
            d0_dl_reg[0] <= sat48(sx50(xc) - sx50(ys));
            d1_dl_reg[0] <= sat48(sx50(xs) + sx50(yc));
            d3_dl_reg[0] <= sat48(sx50(item_reg[B+LM].accel_cmd) + sx50(vyr));
            for (int i = 1; i <= 2 * LM; i++)
            begin
                d0_dl_reg[i] <= d0_dl_reg[i-1];
                d1_dl_reg[i] <= d1_dl_reg[i-1];
                d3_dl_reg[i] <= d3_dl_reg[i-1];
            end

            diff_reg     <= sat48(sx50(lff) - sx50(lrf));
            d4_dl_reg[0] <= sat48(sx50(massm) - sx50(vxr_dl_reg[LM]));
            for (int i = 1; i < LM; i++)
                d4_dl_reg[i] <= d4_dl_reg[i-1];
        end
    end

    always_comb
    begin
        deriv.d_pos_x       = d0_dl_reg[2*LM];
        deriv.d_pos_y       = d1_dl_reg[2*LM];
        deriv.d_heading     = item_reg[P].turn_rate;
        deriv.d_long_vel    = d3_dl_reg[2*LM];
        deriv.d_lat_vel     = d4_dl_reg[LM-1];
        deriv.d_turn_rate   = d5;
        deriv.d_wheel_angle = item_reg[P].steer_rate_cmd;
    end

`ifndef SYNTHESIS
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_heading_folded: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SC_IN] |-> (sc_z_reg[0] <= HALF_PI30 && sc_z_reg[0] >= -HALF_PI30))
        else $error("heading angle not folded into CORDIC range");

    a_steer_folded: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SC_IN] |-> (sc_z_reg[1] <= HALF_PI30 && sc_z_reg[1] >= -HALF_PI30))
        else $error("wheel angle not folded into CORDIC range");

    a_atan_right_half: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[D+6] |-> at_x_reg > 0)
        else $error("atan2 vector not in right half plane");
`endif

endmodule
